FILE: hdl/fence_gated_release_queue_macros.svh
// Assertion macros for the fence gated release queue.
`ifndef FENCE_GATED_RELEASE_QUEUE_MACROS_SVH
`define FENCE_GATED_RELEASE_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FGRQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fgrq assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FGRQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fgrq assertion failed");

`endif

FILE: hdl/fgrq_pkg.sv
// Shared constants, codes and types of the fence gated release queue.
package fgrq_pkg;

    localparam int NUM_QUEUES  = 8;
    localparam int ENTRY_DEPTH = 16;

    localparam int SEQ_W = 32;
    localparam int TAG_W = 16;
    localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int QCW   = $clog2(NUM_QUEUES + 1);
    localparam int SW    = $clog2(ENTRY_DEPTH);
    localparam int CW    = $clog2(ENTRY_DEPTH + 1);
    localparam int NW    = $clog2(ENTRY_DEPTH * NUM_QUEUES);

    localparam logic       FUNC_DEP     = 1'b0;
    localparam logic       FUNC_DONE    = 1'b1;
    localparam logic       KIND_STATUS  = 1'b0;
    localparam logic       KIND_RELEASE = 1'b1;
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic             func;
        logic [2:0]       queue_id;
        logic [SEQ_W-1:0] sequence_req;
        logic             has_dependency;
        logic             entry_end;
        logic [TAG_W-1:0] task_tag;
    } t_in_item;

    typedef struct packed {
        logic             kind;
        logic [1:0]       status;
        logic [TAG_W-1:0] released_tag;
        logic [4:0]       pending_count;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic             needs_we;
        logic [SW-1:0]    wr_slot;
        logic [QW-1:0]    wr_q;
        logic [SEQ_W-1:0] wr_need;
        logic             tag_we;
        logic [TAG_W-1:0] wr_tag;
        logic [SW-1:0]    rd_slot;
        logic [QW-1:0]    rd_q;
    } t_store_cmd;

endpackage

FILE: hdl/fgrq_ifs.sv
// Valid/ready channel interfaces for the request and response sides.
interface fgrq_in_if import fgrq_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fgrq_out_if import fgrq_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/fence_gated_release_queue.sv
// Top level of the fence gated in-order release queue.
//
//  channel  | dir | payload     | transfer
//  i_req    | in  | t_in_item   | valid && ready
//  o_rsp    | out | t_out_item  | valid && ready
//
// A non-final dependency item leaves the queue idle. A commit copies the build
// sequences into the store, one store write per cycle.
// Each head check reads store words through the single read port, stopping at
// the first unmet queue and skipping the reads with an empty store; each released
// entry then takes a pop, and the status comes last.
// Reset clears marks, build state, head and count; the store is not cleared.
// A full output register holds the sequencer; input is taken only when idle.
`include "fence_gated_release_queue_macros.svh"

module fence_gated_release_queue import fgrq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fgrq_in_if.sink    i_req,
    fgrq_out_if.source o_rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_COPY = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_STAT = 3'd4;

    logic [2:0]       r_state,  n_state;
    logic [SEQ_W-1:0] r_mark  [NUM_QUEUES];
    logic [SEQ_W-1:0] n_mark  [NUM_QUEUES];
    logic [SEQ_W-1:0] r_build [NUM_QUEUES];
    logic [SEQ_W-1:0] n_build [NUM_QUEUES];
    logic             r_berr,   n_berr;
    logic [SW-1:0]    r_head,   n_head;
    logic [CW-1:0]    r_count,  n_count;
    logic [1:0]       r_status, n_status;
    logic [TAG_W-1:0] r_tag_in, n_tag_in;
    logic [QCW-1:0]   r_qi,     n_qi;
    logic             r_rv,     n_rv;
    logic [QW-1:0]    r_qd,     n_qd;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out,    n_out;

    t_in_item         req;
    t_store_cmd       cmd;
    logic [SEQ_W-1:0] st_need;
    logic [TAG_W-1:0] st_tag;
    logic             accept;
    logic             q_ok;
    logic             seq_ok;
    logic             dep_bad;
    logic [QW-1:0]    qx;
    logic [QW-1:0]    mark_idx;
    logic [QW-1:0]    build_idx;
    logic [SEQ_W-1:0] mark_rd;
    logic [SEQ_W-1:0] build_rd;
    logic [SW:0]      tail_sum;
    logic [SW-1:0]    tail;
    logic [SW-1:0]    head_next;
    logic             out_free;
    logic             blocked;

    fgrq_store u_store (
        .i_clk  (i_clk),
        .i_cmd  (cmd),
        .o_need (st_need),
        .o_tag  (st_tag)
    );

    assign req          = i_req.data;
    assign i_req.ready  = (r_state == S_IDLE);
    assign accept       = i_req.valid && (r_state == S_IDLE);
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.data   = r_out;
    assign out_free     = !r_out_valid || o_rsp.ready;

    assign q_ok     = (32'(req.queue_id) < NUM_QUEUES);
    assign seq_ok   = (req.sequence_req != '0);
    assign dep_bad  = req.has_dependency && (!seq_ok || !q_ok);
    assign qx       = QW'(req.queue_id);

    assign mark_idx  = (r_state == S_IDLE) ? qx : r_qd;
    assign build_idx = (r_state == S_IDLE) ? qx : QW'(r_qi);
    assign mark_rd   = r_mark[mark_idx];
    assign build_rd  = r_build[build_idx];

    assign tail_sum  = (SW+1)'(r_head) + (SW+1)'(r_count);
    assign tail      = (tail_sum >= (SW+1)'(ENTRY_DEPTH)) ?
                       SW'(tail_sum - (SW+1)'(ENTRY_DEPTH)) : SW'(tail_sum);
    assign head_next = (r_head == SW'(ENTRY_DEPTH - 1)) ? '0 : r_head + SW'(1);

    assign blocked = (st_need != '0) && (mark_rd < st_need);

    always_comb begin
        n_state     = r_state;
        n_mark      = r_mark;
        n_build     = r_build;
        n_berr      = r_berr;
        n_head      = r_head;
        n_count     = r_count;
        n_status    = r_status;
        n_tag_in    = r_tag_in;
        n_qi        = r_qi;
        n_rv        = r_rv;
        n_qd        = r_qd;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;

        cmd          = '0;
        cmd.wr_slot  = tail;
        cmd.wr_q     = QW'(r_qi);
        cmd.wr_need  = build_rd;
        cmd.wr_tag   = r_tag_in;
        cmd.rd_slot  = r_head;
        cmd.rd_q     = QW'(r_qi);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_qi = '0;
                    n_rv = 1'b0;
                    if (req.func == FUNC_DEP) begin
                        if (req.has_dependency && !dep_bad && req.sequence_req > build_rd) begin
                            n_build[qx] = req.sequence_req;
                        end
                        if (!req.entry_end) begin
                            n_berr = r_berr || dep_bad;
                        end else if (r_berr || dep_bad) begin
                            n_status = ST_INVALID;
                            n_build  = '{default: '0};
                            n_berr   = 1'b0;
                            n_state  = S_STAT;
                        end else if (r_count >= CW'(ENTRY_DEPTH)) begin
                            n_status = ST_FULL;
                            n_build  = '{default: '0};
                            n_berr   = 1'b0;
                            n_state  = S_STAT;
                        end else begin
                            n_tag_in = req.task_tag;
                            n_state  = S_COPY;
                        end
                    end else begin
                        if (!seq_ok || !q_ok) begin
                            n_status = ST_INVALID;
                            n_state  = S_STAT;
                        end else begin
                            if (req.sequence_req > mark_rd) begin
                                n_mark[qx] = req.sequence_req;
                            end
                            n_status = ST_OK;
                            n_state  = S_SCAN;
                        end
                    end
                end
            end
            S_COPY: begin
                cmd.needs_we = 1'b1;
                cmd.tag_we   = (r_qi == '0);
                n_qi         = r_qi + QCW'(1);
                if (r_qi == QCW'(NUM_QUEUES - 1)) begin
                    n_build  = '{default: '0};
                    n_berr   = 1'b0;
                    n_count  = r_count + CW'(1);
                    n_status = ST_OK;
                    n_qi     = '0;
                    n_rv     = 1'b0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_count == '0) begin
                    n_state = S_STAT;
                end else begin
                    n_rv = (r_qi < QCW'(NUM_QUEUES));
                    n_qd = QW'(r_qi);
                    if (r_qi < QCW'(NUM_QUEUES)) begin
                        n_qi = r_qi + QCW'(1);
                    end
                    if (r_rv) begin
                        if (blocked) begin
                            n_state = S_STAT;
                        end else if (r_qd == QW'(NUM_QUEUES - 1)) begin
                            n_state = S_POP;
                        end
                    end
                end
            end
            S_POP: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.kind          = KIND_RELEASE;
                    n_out.status        = ST_OK;
                    n_out.released_tag  = st_tag;
                    n_out.pending_count = 5'(r_count - CW'(1));
                    n_out.last          = 1'b0;
                    n_head              = head_next;
                    n_count             = r_count - CW'(1);
                    n_qi                = '0;
                    n_rv                = 1'b0;
                    n_state             = S_SCAN;
                end
            end
            S_STAT: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.kind          = KIND_STATUS;
                    n_out.status        = r_status;
                    n_out.released_tag  = '0;
                    n_out.pending_count = 5'(r_count);
                    n_out.last          = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mark      <= '{default: '0};
            r_build     <= '{default: '0};
            r_berr      <= 1'b0;
            r_head      <= '0;
            r_count     <= '0;
            r_qi        <= '0;
            r_rv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mark      <= n_mark;
            r_build     <= n_build;
            r_berr      <= n_berr;
            r_head      <= n_head;
            r_count     <= n_count;
            r_qi        <= n_qi;
            r_rv        <= n_rv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_tag_in <= n_tag_in;
        r_qd     <= n_qd;
        r_out    <= n_out;
    end

    `FGRQ_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(ENTRY_DEPTH))
    `FGRQ_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, r_state == S_POP, r_count != '0)
    `FGRQ_ASSERT_IMP(a_release_pending, i_clk, i_rst_n,
        r_out_valid && (r_out.kind == KIND_RELEASE), r_out.pending_count == 5'(r_count))
    `FGRQ_ASSERT_NXT(a_zero_done_invalid, i_clk, i_rst_n,
        accept && (req.func == FUNC_DONE) && !seq_ok,
        (r_state == S_STAT) && (r_status == ST_INVALID))

endmodule

FILE: hdl/fgrq_store.sv
// Entry store: per-entry dependency sequences and task tags, registered read.
module fgrq_store import fgrq_pkg::*; (
    input  logic             i_clk,
    input  t_store_cmd       i_cmd,
    output logic [SEQ_W-1:0] o_need,
    output logic [TAG_W-1:0] o_tag
);

    logic [SEQ_W-1:0] r_needs [ENTRY_DEPTH*NUM_QUEUES];
    logic [TAG_W-1:0] r_tags  [ENTRY_DEPTH];
    logic [NW-1:0]    wr_addr;
    logic [NW-1:0]    rd_addr;

    assign wr_addr = NW'(NW'(i_cmd.wr_slot) * NW'(NUM_QUEUES)) + NW'(i_cmd.wr_q);
    assign rd_addr = NW'(NW'(i_cmd.rd_slot) * NW'(NUM_QUEUES)) + NW'(i_cmd.rd_q);

    always_ff @(posedge i_clk) begin
        if (i_cmd.needs_we) begin
            r_needs[wr_addr] <= i_cmd.wr_need;
        end
        o_need <= r_needs[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tag_we) begin
            r_tags[i_cmd.wr_slot] <= i_cmd.wr_tag;
        end
        o_tag <= r_tags[i_cmd.rd_slot];
    end

endmodule

FILE: test/tb.sv
// Testbench for fence_gated_release_queue: random stimulus checked against a scoreboard.
module tb import fgrq_pkg::*; ();

    localparam int IDLE_LIMIT = 4000;
    localparam int ITEM_GOAL  = 220;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} t_mode;

    class release_scoreboard;
        logic [SEQ_W-1:0] marks [NUM_QUEUES];
        logic [SEQ_W-1:0] slot_needs [ENTRY_DEPTH][NUM_QUEUES];
        logic [TAG_W-1:0] slot_tags [ENTRY_DEPTH];
        logic [SW-1:0]    head;
        logic [CW-1:0]    count;
        logic [SEQ_W-1:0] draft_needs [NUM_QUEUES];
        logic             draft_bad;
        t_out_item        due [$];
        int               errors;

        function new();
            foreach (marks[q]) marks[q] = '0;
            foreach (draft_needs[q]) draft_needs[q] = '0;
            head      = '0;
            count     = '0;
            draft_bad = 1'b0;
            errors    = 0;
        endfunction

        function void add_due(t_out_item r);
            due = {due, r};
        endfunction

        function bit head_met();
            for (int q = 0; q < NUM_QUEUES; q++) begin
                if (slot_needs[head][q] != 0 && marks[q] < slot_needs[head][q]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void release_ready();
            t_out_item r;
            while (count != 0 && head_met()) begin
                r.kind          = KIND_RELEASE;
                r.status        = ST_OK;
                r.released_tag  = slot_tags[head];
                count           = count - CW'(1);
                r.pending_count = count;
                r.last          = 1'b0;
                head            = head + SW'(1);
                add_due(r);
            end
        endfunction

        function void note_request(t_in_item it);
            logic [1:0]    st;
            logic [SW-1:0] slot;
            t_out_item     r;
            st = ST_OK;
            if (it.func == FUNC_DEP) begin
                if (it.has_dependency) begin
                    if (it.sequence_req == 0 || it.queue_id >= NUM_QUEUES)
                        draft_bad = 1'b1;
                    else if (it.sequence_req > draft_needs[it.queue_id])
                        draft_needs[it.queue_id] = it.sequence_req;
                end
                if (!it.entry_end) return;
                if (draft_bad) begin
                    st = ST_INVALID;
                end else if (count >= ENTRY_DEPTH) begin
                    st = ST_FULL;
                end else begin
                    slot = head + count[SW-1:0];
                    for (int q = 0; q < NUM_QUEUES; q++) slot_needs[slot][q] = draft_needs[q];
                    slot_tags[slot] = it.task_tag;
                    count = count + CW'(1);
                    release_ready();
                end
                foreach (draft_needs[q]) draft_needs[q] = '0;
                draft_bad = 1'b0;
            end else begin
                if (it.sequence_req == 0 || it.queue_id >= NUM_QUEUES) begin
                    st = ST_INVALID;
                end else begin
                    if (it.sequence_req > marks[it.queue_id]) marks[it.queue_id] = it.sequence_req;
                    release_ready();
                end
            end
            r.kind          = KIND_STATUS;
            r.status        = st;
            r.released_tag  = '0;
            r.pending_count = count;
            r.last          = 1'b1;
            add_due(r);
        endfunction

        function void report(string what);
            errors++;
            if (errors <= 10) $display("%0t: %s", $time, what);
        endfunction

        function void check_response(t_out_item got);
            t_out_item want;
            if (due.size() == 0) begin
                report($sformatf("unexpected result kind %0d status %0d tag %h pending %0d last %0d",
                                 got.kind, got.status, got.released_tag, got.pending_count,
                                 got.last));
                return;
            end
            want = due.pop_front();
            if (got.kind !== want.kind || got.status !== want.status ||
                got.released_tag !== want.released_tag ||
                got.pending_count !== want.pending_count || got.last !== want.last)
                report($sformatf({"mismatch: expected kind %0d status %0d tag %h pending %0d",
                                  " last %0d, got kind %0d status %0d tag %h pending %0d last %0d"},
                                 want.kind, want.status, want.released_tag, want.pending_count,
                                 want.last, got.kind, got.status, got.released_tag,
                                 got.pending_count, got.last));
        endfunction

        function int outstanding();
            return due.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    fgrq_in_if  req_ch ();
    fgrq_out_if rsp_ch ();

    fence_gated_release_queue uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    release_scoreboard sb;
    bit calm        = 1'b0;
    int sent_items  = 0;
    int rsp_stall   = 0;
    int idle_cycles = 0;

    always #6 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item mk(logic f, logic [2:0] q, logic [SEQ_W-1:0] s, logic d,
                                    logic e, logic [TAG_W-1:0] t);
        t_in_item it;
        it.func           = f;
        it.queue_id       = q;
        it.sequence_req   = s;
        it.has_dependency = d;
        it.entry_end      = e;
        it.task_tag       = t;
        return it;
    endfunction

    task automatic send_req(input t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= it;
        do @(negedge i_clk); while (req_ch.ready !== 1'b1);
        sb.note_request(it);
        @(posedge i_clk);
        if (!(it.func == FUNC_DEP && !it.entry_end && !it.has_dependency)) sent_items++;
    endtask

    function automatic logic [SEQ_W-1:0] pick_need(logic [2:0] q, t_mode m);
        int r;
        int unmet;
        r     = $urandom_range(0, 99);
        unmet = (m == MODE_FILL) ? 75 : 40;
        if (r < 3) return $urandom | 1;
        if (r < 6) return '0;
        if (r < 6 + unmet || sb.marks[q] == 0) return sb.marks[q] + $urandom_range(1, 8);
        return $urandom_range(sb.marks[q], 1);
    endfunction

    task automatic send_entry(input t_mode m);
        int       parts;
        t_in_item it;
        parts = $urandom_range(1, 4);
        for (int i = 0; i < parts; i++) begin
            it.func           = FUNC_DEP;
            it.queue_id       = 3'($urandom_range(0, NUM_QUEUES - 1));
            it.has_dependency = ($urandom_range(0, 4) != 0);
            it.sequence_req   = it.has_dependency ? pick_need(it.queue_id, m) : $urandom;
            it.entry_end      = (i == parts - 1);
            it.task_tag       = TAG_W'($urandom);
            send_req(it);
        end
    endtask

    task automatic send_completion(input t_mode m);
        int               r;
        int               start;
        logic [2:0]       q;
        logic [SEQ_W-1:0] s;
        logic [SEQ_W-1:0] need;
        q = 3'($urandom_range(0, NUM_QUEUES - 1));
        s = sb.marks[q] + $urandom_range(1, 3);
        r = $urandom_range(0, 99);
        if ((m == MODE_DRAIN || r < 30) && sb.count != 0) begin
            // aim at an unmet need of the head entry so the store drains
            start = $urandom_range(0, NUM_QUEUES - 1);
            for (int i = 0; i < NUM_QUEUES; i++) begin
                need = sb.slot_needs[sb.head][(start + i) % NUM_QUEUES];
                if (need != 0 && need > sb.marks[(start + i) % NUM_QUEUES]) begin
                    q = 3'((start + i) % NUM_QUEUES);
                    s = need + $urandom_range(0, 1);
                    break;
                end
            end
        end else if (r < 38) begin
            s = $urandom;
        end else if (r < 43) begin
            s = '0;
        end
        send_req(mk(FUNC_DONE, q, s, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    TAG_W'($urandom)));
    endtask

    always @(posedge i_clk) begin
        if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_stall = pick_gap();
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_response(rsp_ch.data);
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("fence_gated_release_queue test failed");
            $finish;
        end
    end

    initial begin
        t_mode m;
        int    steps;
        int    r;
        sb           = new();
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // entry without dependencies releases at once
        send_req(mk(FUNC_DEP, 3'd0, '0, 1'b0, 1'b1, 16'h0000));
        // same queue merges by maximum; all-ones sequence and tag
        send_req(mk(FUNC_DEP, 3'd0, 32'd5, 1'b1, 1'b0, 16'h0000));
        send_req(mk(FUNC_DEP, 3'd0, 32'd3, 1'b1, 1'b0, 16'h0000));
        send_req(mk(FUNC_DEP, 3'd7, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF));
        // ready entry held behind a blocked head; queue and sequence ignored
        send_req(mk(FUNC_DEP, 3'd5, 32'hA5A5_A5A5, 1'b0, 1'b1, 16'h1234));
        // zero-sequence completion
        send_req(mk(FUNC_DONE, 3'd0, '0, 1'b0, 1'b0, 16'h0000));
        send_req(mk(FUNC_DONE, 3'd0, 32'd4, 1'b1, 1'b1, 16'hFFFF));
        send_req(mk(FUNC_DONE, 3'd0, 32'd5, 1'b0, 1'b0, 16'h0000));
        send_req(mk(FUNC_DONE, 3'd7, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'h0000));
        // lower completion leaves the mark alone
        send_req(mk(FUNC_DONE, 3'd0, 32'd2, 1'b0, 1'b0, 16'h0000));
        // zero sequence in a dependency drops the entry and clears the build
        send_req(mk(FUNC_DEP, 3'd2, '0, 1'b1, 1'b0, 16'h0000));
        send_req(mk(FUNC_DEP, 3'd3, 32'd9, 1'b1, 1'b1, 16'h5A5A));
        send_req(mk(FUNC_DEP, 3'd0, 32'd3, 1'b1, 1'b1, 16'hA5A5));
        send_req(mk(FUNC_DEP, 3'd6, '0, 1'b1, 1'b1, 16'h00FF));

        while (sent_items < ITEM_GOAL) begin
            r     = $urandom_range(0, 9);
            m     = (r < 3) ? MODE_FILL : (r < 5) ? MODE_DRAIN : MODE_MIXED;
            calm  = ($urandom_range(0, 4) == 0);
            steps = (m == MODE_FILL) ? $urandom_range(10, 24) : $urandom_range(4, 12);
            repeat (steps) begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    send_req(mk(1'($urandom_range(0, 1)), 3'($urandom), $urandom,
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                TAG_W'($urandom)));
                else if (r < ((m == MODE_FILL) ? 90 : (m == MODE_DRAIN) ? 20 : 50))
                    send_entry(m);
                else
                    send_completion(m);
            end
        end
        calm = 1'b0;
        req_ch.valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0)
            $display("fence_gated_release_queue test passed");
        else
            $display("fence_gated_release_queue test failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/fgrq_pkg.sv
hdl/fgrq_ifs.sv
hdl/fgrq_store.sv
hdl/fence_gated_release_queue.sv
test/tb.sv
